[rtl/ttcf_pkg.sv]
// Shared constants and widths for the textured trapezoid column fill.
package ttcf_pkg;
	localparam int TEX_DIM_MAX = 32;
	localparam int SCREEN_COLS = 80;
	localparam int SCREEN_ROWS = 24;
	localparam int TEX_IDX_W   = $clog2(TEX_DIM_MAX);
	localparam int TEX_ADDR_W  = 2 * TEX_IDX_W;
	localparam int ADDR_W      = 11;
	localparam int CHAR_W      = 8;
	localparam int COL_W       = 10;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int DIM_W       = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_TOP    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOPE_BOTTOM = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ICEPT_TOP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ICEPT_BOTTOM = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_COL     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_COL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT   = 3'd7;

	// item operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;
endpackage

[rtl/ttcf_item_if.sv]
// Input item channel: texel loads and column draws.
interface ttcf_item_if import ttcf_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic signed [COL_W-1:0]    column;
	logic [TEX_IDX_W-1:0]       texel_col;
	logic [TEX_IDX_W-1:0]       texel_row;
	logic [CHAR_W-1:0]          texel_char;

	modport source (output valid, op, column, texel_col, texel_row, texel_char, input ready);
	modport sink (input valid, op, column, texel_col, texel_row, texel_char, output ready);
endinterface

[rtl/ttcf_result_if.sv]
// Result channel: one screen cell write per transfer.
interface ttcf_result_if import ttcf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ADDR_W-1:0]   screen_addr;
	logic [CHAR_W-1:0]   pixel_char;
	logic                last;

	modport source (output valid, screen_addr, pixel_char, last, input ready);
	modport sink (input valid, screen_addr, pixel_char, last, output ready);
endinterface

[rtl/textured_trapezoid_column_fill.sv]
// Top level: texture store and column draw sequencer.
// Load item: no result; the next item is taken in the following cycle.
// Draw item: set-up (edge multiply, rounding, 5-step column ratio division),
// then for each visible row a 5-step row ratio division, a registered texture
// read and an output register load that waits while the result slot is full.
// One item is in work at a time; both ratio divisions share one radix-2 divider.
// arst_n clears control state and configuration; the texture store is undefined until written.
module textured_trapezoid_column_fill import ttcf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	ttcf_item_if.sink             item,
	ttcf_result_if.source         result
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_EDGE, S_DIV, S_DDONE, S_YSET, S_RD, S_EMIT
	} state_t;

	// configuration
	logic signed [31:0]      slope_top_q, slope_bot_q, icept_top_q, icept_bot_q;
	logic signed [COL_W-1:0] left_q, right_q;
	logic [DIM_W-1:0]        tw_q, th_q, tw_c, th_c;

	state_t state_q;

	// column work
	logic [6:0]              x_q;     // screen column, 0..79 once accepted
	logic [COL_W:0]          xn_q;    // offset into span
	logic [COL_W:0]          xd_q;    // span width
	logic signed [40:0]      et_q, eb_q;
	logic signed [25:0]      top_q, top_c, bot_c;
	logic [31:0]             il_q;
	logic [4:0]              y_q, y1_q;
	logic [TEX_IDX_W-1:0]    xi_q, yi_q;

	// shared ratio divider, quotient known to stay below TEX_DIM_MAX
	logic [36:0]             div_rem_q, div_sh;
	logic [31:0]             div_d_q;
	logic [DIM_W-1:0]        div_lim_q, div_qr;
	logic [TEX_IDX_W-1:0]    div_q_q;
	logic [2:0]              div_cnt_q;
	logic                    div_y_q;

	// texture store
	logic [CHAR_W-1:0]       tex_mem [TEX_DIM_MAX*TEX_DIM_MAX];
	logic [CHAR_W-1:0]       tex_rd_q;

	// result register
	logic                    out_valid_q, out_last_q;
	logic [ADDR_W-1:0]       out_addr_q;
	logic [CHAR_W-1:0]       out_char_q;

	logic                    take, in_span, on_screen, slot_free;
	logic signed [COL_W:0]   col_w, left_w, right_w;
	logic signed [26:0]      ydiff;
	logic [4:0]              y0_c, y1_c;
	logic                    rows_empty;

	// Q16.16 to integer: truncate toward zero, round up above one half when positive
	function automatic logic signed [25:0] round_q16(input logic signed [40:0] v);
		logic signed [40:0] mag;
		logic signed [25:0] r;
		begin
			if (v < 0) begin
				mag = -v;
				r = -$signed({1'b0, mag[40:16]});
			end else begin
				r = $signed({1'b0, v[40:16]}) + ((v[15:0] > 16'h8000) ? 26'sd1 : 26'sd0);
			end
			return r;
		end
	endfunction

	assign tw_c = (tw_q == '0) ? DIM_W'(1) :
		(tw_q > DIM_W'(TEX_DIM_MAX)) ? DIM_W'(TEX_DIM_MAX) : tw_q;
	assign th_c = (th_q == '0) ? DIM_W'(1) :
		(th_q > DIM_W'(TEX_DIM_MAX)) ? DIM_W'(TEX_DIM_MAX) : th_q;

	assign item.ready = (state_q == S_IDLE);
	assign take       = item.valid && item.ready;
	assign slot_free  = !out_valid_q || result.ready;

	assign col_w     = (COL_W+1)'(item.column);
	assign left_w    = (COL_W+1)'(left_q);
	assign right_w   = (COL_W+1)'(right_q);
	assign in_span   = (item.column >= left_q) && (item.column <= right_q);
	assign on_screen = (item.column >= 0) && (item.column < COL_W'(SCREEN_COLS));

	assign top_c = round_q16(et_q);
	assign bot_c = round_q16(eb_q);
	assign y0_c  = (top_c < 0) ? 5'd0 : top_c[4:0];
	assign y1_c  = (bot_c > 26'(SCREEN_ROWS - 1)) ? 5'(SCREEN_ROWS - 1) : bot_c[4:0];
	// nothing visible when the span lies wholly above or below the screen
	assign rows_empty = (bot_c < 0) || (top_c > 26'(SCREEN_ROWS - 1));

	assign ydiff  = $signed({22'd0, y_q}) - 27'(top_q);
	assign div_sh = {5'd0, div_d_q} << div_cnt_q;

	always_comb begin
		div_qr = {1'b0, div_q_q} + (({div_rem_q, 1'b0} > {6'd0, div_d_q}) ? DIM_W'(1) : '0);
		if (div_qr >= div_lim_q) div_qr = div_lim_q - DIM_W'(1);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slope_top_q <= '0;
			slope_bot_q <= '0;
			icept_top_q <= '0;
			icept_bot_q <= '0;
			left_q      <= '0;
			right_q     <= '0;
			tw_q        <= DIM_W'(1);
			th_q        <= DIM_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SLOPE_TOP:    slope_top_q <= $signed(cfg_wdata);
				REG_SLOPE_BOTTOM: slope_bot_q <= $signed(cfg_wdata);
				REG_ICEPT_TOP:    icept_top_q <= $signed(cfg_wdata);
				REG_ICEPT_BOTTOM: icept_bot_q <= $signed(cfg_wdata);
				REG_LEFT_COL:     left_q      <= $signed(cfg_wdata[COL_W-1:0]);
				REG_RIGHT_COL:    right_q     <= $signed(cfg_wdata[COL_W-1:0]);
				REG_TEX_WIDTH:    tw_q        <= cfg_wdata[DIM_W-1:0];
				REG_TEX_HEIGHT:   th_q        <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// texture store: load writes, one registered read per row
	always_ff @(posedge clk) begin
		if (take && item.op == OP_LOAD)
			tex_mem[{item.texel_row, item.texel_col}] <= item.texel_char;
		if (state_q == S_RD)
			tex_rd_q <= tex_mem[{yi_q, xi_q}];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// the emit state reloads the slot itself
			if (out_valid_q && result.ready && state_q != S_EMIT) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (take && item.op == OP_DRAW && in_span && on_screen) begin
						x_q     <= item.column[6:0];
						xn_q    <= (COL_W+1)'(col_w - left_w);
						xd_q    <= (COL_W+1)'(right_w - left_w + (COL_W+1)'(1));
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					et_q    <= $signed({1'b0, x_q}) * slope_top_q + icept_top_q;
					eb_q    <= $signed({1'b0, x_q}) * slope_bot_q + icept_bot_q;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					top_q     <= top_c;
					il_q      <= 32'(bot_c - top_c + 26'sd1);
					y_q       <= y0_c;
					y1_q      <= y1_c;
					div_rem_q <= 37'(xn_q) * 37'(tw_c);
					div_d_q   <= 32'(xd_q);
					div_lim_q <= tw_c;
					div_q_q   <= '0;
					div_cnt_q <= 3'(TEX_IDX_W - 1);
					div_y_q   <= 1'b0;
					state_q   <= (bot_c < top_c || rows_empty) ? S_IDLE : S_DIV;
				end
				S_DIV: begin
					// one quotient bit a cycle, most significant first
					if (div_rem_q >= div_sh) begin
						div_rem_q          <= div_rem_q - div_sh;
						div_q_q[div_cnt_q] <= 1'b1;
					end
					div_cnt_q <= div_cnt_q - 3'd1;
					if (div_cnt_q == '0) state_q <= S_DDONE;
				end
				S_DDONE: begin
					if (div_y_q) begin
						yi_q    <= div_qr[TEX_IDX_W-1:0];
						state_q <= S_RD;
					end else begin
						xi_q    <= div_qr[TEX_IDX_W-1:0];
						state_q <= S_YSET;
					end
				end
				S_YSET: begin
					div_rem_q <= 37'(ydiff[25:0]) * 37'(th_c);
					div_d_q   <= il_q;
					div_lim_q <= th_c;
					div_q_q   <= '0;
					div_cnt_q <= 3'(TEX_IDX_W - 1);
					div_y_q   <= 1'b1;
					state_q   <= S_DIV;
				end
				S_RD: state_q <= S_EMIT;
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_addr_q  <= ADDR_W'(x_q) + ADDR_W'(y_q) * ADDR_W'(SCREEN_COLS);
						out_char_q  <= tex_rd_q;
						out_last_q  <= (y_q == y1_q);
						y_q         <= y_q + 5'd1;
						state_q     <= (y_q == y1_q) ? S_IDLE : S_YSET;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result.valid       = out_valid_q;
	assign result.screen_addr = out_addr_q;
	assign result.pixel_char  = out_char_q;
	assign result.last        = out_last_q;

	// divider leaves a proper remainder
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DDONE |-> div_rem_q < {5'd0, div_d_q})
		else $error("divider remainder not below divisor");
	// column index lies inside the texture in use
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_YSET |-> {1'b0, xi_q} < tw_c)
		else $error("texture column out of range");
	// rows emitted never run past the clipped bottom
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT |-> y_q <= y1_q)
		else $error("row past bottom");
	// writes land on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_addr_q < ADDR_W'(SCREEN_COLS * SCREEN_ROWS))
		else $error("screen address out of range");
endmodule

[dv/tb_top.sv]
// Testbench for the textured trapezoid column fill: directed table, texture fill, fixed and random phases.
`timescale 1ns / 1ps

module tb_top;
	import ttcf_pkg::*;

	// one stimulus item as it goes onto the item channel
	typedef struct {
		logic                 op;
		logic [COL_W-1:0]     column;
		logic [TEX_IDX_W-1:0] texel_col;
		logic [TEX_IDX_W-1:0] texel_row;
		logic [CHAR_W-1:0]    texel_char;
	} item_t;

	// one screen cell write as it leaves the result channel
	typedef struct {
		logic [ADDR_W-1:0] screen_addr;
		logic [CHAR_W-1:0] pixel_char;
		logic              last;
	} cell_write_t;

	// how a directed row is checked
	typedef enum int {CHK_PREDICT, CHK_ONE_WRITE, CHK_NO_WRITE} row_check_t;

	typedef struct {
		item_t       it;
		row_check_t  chk;
		cell_write_t wr;
	} dir_row_t;

	localparam int DRAW_LATENCY = 11 + 9 * SCREEN_ROWS + 40;

	logic clk;
	logic arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	ttcf_item_if   item_ch ();
	ttcf_result_if result_ch ();

	textured_trapezoid_column_fill u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.item      (item_ch),
		.result    (result_ch)
	);

	// shadow of the block: registers and texture store
	logic [CFG_DATA_W-1:0] reg_shadow [8];
	logic [CHAR_W-1:0]     texel_shadow [TEX_DIM_MAX*TEX_DIM_MAX];

	cell_write_t pending_writes [$];
	int          err_count;
	int          writes_seen;
	int          burst_left;

	// clock: 10 ns period
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// generous hard stop; a correct run finishes far earlier
	initial begin
		#5ms;
		$display("simulation failed");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Q16.16 to integer row: negative values truncate toward zero,
	// positive ones round up only when the fraction is over one half
	function automatic longint round_q16(input longint v);
		longint unsigned mag;
		longint          r;
		if (v < 0) begin
			mag = -v;
			return -longint'(mag >> 16);
		end
		r = v >>> 16;
		if (v[15:0] > 16'h8000)
			r++;
		return r;
	endfunction

	// exact rounded n*lim/d, an index equal to lim knocked back by one
	function automatic longint unsigned tex_index(input longint unsigned n,
		input longint unsigned d, input longint unsigned lim);
		longint unsigned p, q, r;
		p = n * lim;
		q = p / d;
		r = p % d;
		if (2 * r > d)
			q++;
		if (q >= lim)
			q = lim - 1;
		return q;
	endfunction

	function automatic longint unsigned clamp_dim(input logic [DIM_W-1:0] d);
		if (d < 1)
			return 1;
		if (d > TEX_DIM_MAX)
			return TEX_DIM_MAX;
		return d;
	endfunction

	// expected cell writes of one draw, appended to the pending queue
	task automatic predict_column(input logic [COL_W-1:0] colv);
		longint          x, lo, hi, top, bot, y, y0, y1;
		longint unsigned tw, th, xi, yi, il;
		cell_write_t     w;
		bit              any;
		x  = longint'($signed(colv));
		lo = longint'($signed(reg_shadow[REG_LEFT_COL][COL_W-1:0]));
		hi = longint'($signed(reg_shadow[REG_RIGHT_COL][COL_W-1:0]));
		if (x < lo || x > hi || x < 0 || x >= SCREEN_COLS)
			return;
		tw = clamp_dim(reg_shadow[REG_TEX_WIDTH][DIM_W-1:0]);
		th = clamp_dim(reg_shadow[REG_TEX_HEIGHT][DIM_W-1:0]);
		xi = tex_index(x - lo, hi - lo + 1, tw);
		top = round_q16(x * longint'($signed(reg_shadow[REG_SLOPE_TOP]))
			+ longint'($signed(reg_shadow[REG_ICEPT_TOP])));
		bot = round_q16(x * longint'($signed(reg_shadow[REG_SLOPE_BOTTOM]))
			+ longint'($signed(reg_shadow[REG_ICEPT_BOTTOM])));
		if (bot < top)
			return;
		il = bot - top + 1;
		y0 = (top < 0) ? 0 : top;
		y1 = (bot > SCREEN_ROWS - 1) ? SCREEN_ROWS - 1 : bot;
		any = 1'b0;
		for (y = y0; y <= y1; y++) begin
			yi = tex_index(y - top, il, th);
			w.screen_addr = ADDR_W'(x + SCREEN_COLS * y);
			w.pixel_char  = texel_shadow[xi + TEX_DIM_MAX * yi];
			w.last        = 1'b0;
			pending_writes = {pending_writes, w};
			any = 1'b1;
		end
		if (any)
			pending_writes[pending_writes.size() - 1].last = 1'b1;
	endtask

	// offer one item and hold it until the transfer; the sender runs in bursts
	task automatic send_item(input item_t it, input row_check_t chk, input cell_write_t wr);
		@(negedge clk);
		item_ch.valid      <= 1'b1;
		item_ch.op         <= it.op;
		item_ch.column     <= it.column;
		item_ch.texel_col  <= it.texel_col;
		item_ch.texel_row  <= it.texel_row;
		item_ch.texel_char <= it.texel_char;
		do
			@(posedge clk);
		while (!item_ch.ready);
		// transfer taken: update the shadow and the expectations
		if (it.op == OP_LOAD) begin
			texel_shadow[it.texel_col + TEX_DIM_MAX * it.texel_row] = it.texel_char;
		end else if (chk == CHK_ONE_WRITE) begin
			pending_writes = {pending_writes, wr};
		end else if (chk == CHK_PREDICT) begin
			predict_column(it.column);
		end
		burst_left--;
		if (burst_left <= 0) begin
			@(negedge clk);
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(0, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
	endtask

	// write all eight registers back to back; only called with the block idle
	task automatic write_regs(input logic [CFG_DATA_W-1:0] v [8]);
		for (int i = 0; i < 8; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_idx   <= CFG_IDX_W'(i);
			cfg_wdata <= v[i];
			reg_shadow[i] = v[i];
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender pauses: every expected write back, then the draw latency again
	task automatic drain();
		@(negedge clk);
		item_ch.valid <= 1'b0;
		wait (pending_writes.size() == 0);
		repeat (DRAW_LATENCY) @(negedge clk);
	endtask

	function automatic item_t random_item();
		item_t it;
		int    r, lo, hi;
		r  = $urandom_range(0, 99);
		lo = $signed(reg_shadow[REG_LEFT_COL][COL_W-1:0]);
		hi = $signed(reg_shadow[REG_RIGHT_COL][COL_W-1:0]);
		if (lo < 0)
			lo = 0;
		if (hi > SCREEN_COLS - 1)
			hi = SCREEN_COLS - 1;
		it.op         = OP_DRAW;
		it.column     = COL_W'($urandom);
		it.texel_col  = TEX_IDX_W'($urandom);
		it.texel_row  = TEX_IDX_W'($urandom);
		it.texel_char = CHAR_W'($urandom);
		// mostly columns that land inside the span and on screen
		if (r < 75 && lo <= hi)
			it.column = COL_W'($urandom_range(lo, hi));
		else if (r >= 85)
			it.op = OP_LOAD;
		return it;
	endfunction

	// receiver: ready patterns picked at random from four, plus one long hold-off
	initial begin
		int  cyc;
		bit  held;
		int  mode;
		result_ch.ready = 1'b0;
		held = 1'b0;
		cyc  = 0;
		mode = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && writes_seen >= 40) begin
				// long stall: the block fills up and must back-pressure the items
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (600) @(negedge clk);
			end else begin
				if (cyc % 64 == 0)
					mode = $urandom_range(0, 3);
				case (mode)
					0: result_ch.ready <= 1'b1;
					1: result_ch.ready <= ($urandom_range(0, 1) == 1);
					2: result_ch.ready <= ($urandom_range(0, 3) == 0);
					default: result_ch.ready <= ($urandom_range(0, 7) != 0);
				endcase
				cyc++;
			end
		end
	end

	// result checker: each transfer against the oldest expectation
	always @(posedge clk) begin
		cell_write_t exp_w;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			writes_seen++;
			if (pending_writes.size() == 0) begin
				report_mismatch($sformatf("unexpected write addr %0d char %02h",
					result_ch.screen_addr, result_ch.pixel_char));
			end else begin
				exp_w = pending_writes.pop_front();
				if (result_ch.screen_addr !== exp_w.screen_addr)
					report_mismatch($sformatf("screen_addr %0d, want %0d",
						result_ch.screen_addr, exp_w.screen_addr));
				if (result_ch.pixel_char !== exp_w.pixel_char)
					report_mismatch($sformatf("pixel_char %02h, want %02h at addr %0d",
						result_ch.pixel_char, exp_w.pixel_char, exp_w.screen_addr));
				if (result_ch.last !== exp_w.last)
					report_mismatch($sformatf("last %b, want %b at addr %0d",
						result_ch.last, exp_w.last, exp_w.screen_addr));
			end
		end
	end

	// main sequence
	initial begin
		dir_row_t              dir_rows [$];
		dir_row_t              row;
		cell_write_t           none_w;
		item_t                 it;
		logic [CFG_DATA_W-1:0] phase_regs [8];
		logic [CFG_DATA_W-1:0] fixed_phases [7][8];

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_idx            = '0;
		cfg_wdata          = '0;
		item_ch.valid      = 1'b0;
		item_ch.op         = OP_LOAD;
		item_ch.column     = '0;
		item_ch.texel_col  = '0;
		item_ch.texel_row  = '0;
		item_ch.texel_char = '0;
		err_count   = 0;
		writes_seen = 0;
		burst_left  = $urandom_range(1, 12);
		none_w      = '{'0, '0, 1'b0};
		for (int i = 0; i < 8; i++)
			reg_shadow[i] = '0;
		reg_shadow[REG_TEX_WIDTH]  = 1;
		reg_shadow[REG_TEX_HEIGHT] = 1;

		// register sets per phase:
		// slope_top, slope_bottom, icept_top, icept_bottom, left, right, width, height
		fixed_phases = '{
			// ordinary trapezoid, bottom intercept fraction just over a half
			'{32'h0000_4000, 32'h0000_2000, 32'h0002_0000, 32'h0012_8001,
			  32'd10, 32'd60, 32'd4, 32'd4},
			// every field at its extreme; sizes 63 and 0 get clamped
			'{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			  32'h200, 32'h1FF, 32'd63, 32'd0},
			// bottom edge above the top edge: nothing drawn
			'{32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0005_0000,
			  32'd0, 32'd79, 32'd1, 32'd33},
			// top rounds on an exact half (down), bottom climbs onto the screen
			'{32'hFFFF_8000, 32'h0001_0000, 32'h0014_8000, 32'hFFD8_0000,
			  32'd0, 32'd79, 32'd3, 32'd4},
			// empty span
			'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0017_0000,
			  32'd30, 32'd20, 32'd8, 32'd8},
			// span reaching off both screen edges, rows partly off screen
			'{32'hFFFF_F000, 32'h0000_3000, 32'hFFFE_0000, 32'h0017_0000,
			  32'h39C, 32'd200, 32'd4, 32'd3},
			// one-column span at the right screen edge, negative fraction top
			'{32'h0000_0000, 32'h0000_0000, 32'hFFFF_8000, 32'h7FFF_FFFF,
			  32'd79, 32'd79, 32'd32, 32'd32}
		};

		// directed table against the reset settings: span 0..0, 1x1 texture, flat edges
		dir_rows = '{
			'{'{OP_LOAD, 10'd0,    5'd0,  5'd0,  8'hA5}, CHK_NO_WRITE,  none_w},
			'{'{OP_DRAW, 10'd0,    5'd0,  5'd0,  8'h00}, CHK_ONE_WRITE, '{11'd0, 8'hA5, 1'b1}},
			'{'{OP_LOAD, 10'd0,    5'd31, 5'd31, 8'hFF}, CHK_NO_WRITE,  none_w},
			'{'{OP_LOAD, 10'd0,    5'd0,  5'd0,  8'h5A}, CHK_NO_WRITE,  none_w},
			'{'{OP_DRAW, 10'd0,    5'd31, 5'd31, 8'hFF}, CHK_ONE_WRITE, '{11'd0, 8'h5A, 1'b1}},
			'{'{OP_DRAW, 10'd1,    5'd0,  5'd0,  8'h00}, CHK_NO_WRITE,  none_w},
			'{'{OP_DRAW, 10'h3FF,  5'd0,  5'd0,  8'h00}, CHK_NO_WRITE,  none_w},
			'{'{OP_DRAW, 10'h200,  5'd0,  5'd0,  8'h00}, CHK_NO_WRITE,  none_w},
			'{'{OP_DRAW, 10'h1FF,  5'd0,  5'd0,  8'h00}, CHK_NO_WRITE,  none_w},
			'{'{OP_LOAD, 10'h3FF,  5'd31, 5'd0,  8'h00}, CHK_NO_WRITE,  none_w},
			'{'{OP_LOAD, 10'h3FF,  5'd0,  5'd31, 8'h81}, CHK_NO_WRITE,  none_w},
			'{'{OP_DRAW, 10'd0,    5'd0,  5'd0,  8'h00}, CHK_PREDICT,   none_w}
		};

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_item(row.it, row.chk, row.wr);
		end

		// fill the 4x4 corner and the whole of row 0: every phase reads only there
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < TEX_DIM_MAX; c++) begin
				if (r == 0 || c < 4) begin
					it = '{OP_LOAD, COL_W'($urandom), TEX_IDX_W'(c), TEX_IDX_W'(r),
						CHAR_W'($urandom)};
					send_item(it, CHK_NO_WRITE, none_w);
				end
			end
		end

		// fixed phases, then two with random settings
		for (int ph = 0; ph < 9; ph++) begin
			drain();
			if (ph < 7) begin
				phase_regs = fixed_phases[ph];
			end else begin
				phase_regs[REG_SLOPE_TOP]    = $urandom_range(0, 32'h6_0000) - 32'h3_0000;
				phase_regs[REG_SLOPE_BOTTOM] = $urandom_range(0, 32'h6_0000) - 32'h3_0000;
				phase_regs[REG_ICEPT_TOP]    = $urandom_range(0, 32'h28_0000) - 32'h0A_0000;
				phase_regs[REG_ICEPT_BOTTOM] = $urandom_range(0, 32'h28_0000) - 32'h0A_0000;
				phase_regs[REG_LEFT_COL]     = CFG_DATA_W'(10'($urandom_range(0, 100) - 20));
				phase_regs[REG_RIGHT_COL]    = CFG_DATA_W'(10'($signed(
					phase_regs[REG_LEFT_COL][COL_W-1:0]) + $urandom_range(0, 90)));
				phase_regs[REG_TEX_WIDTH]    = $urandom_range(0, 4);
				phase_regs[REG_TEX_HEIGHT]   = $urandom_range(0, 4);
			end
			write_regs(phase_regs);
			repeat (5) begin
				it = random_item();
				send_item(it, CHK_PREDICT, none_w);
			end
		end

		@(negedge clk);
		item_ch.valid <= 1'b0;
		wait (pending_writes.size() == 0);
		repeat (DRAW_LATENCY) @(posedge clk);

		if (err_count == 0 && pending_writes.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
